### rtl/lcdw_pkg.sv
// Shared types and constants for the character LCD 4-bit write sequencer.
// No dependencies; imported by every module of the block.
package lcdw_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned InitCount = 6;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PULSE        = 3'd0,
    REG_GAP          = 3'd1,
    REG_DATA_WAIT    = 3'd2,
    REG_COMMAND_WAIT = 3'd3,
    REG_POWERUP      = 3'd4,
    REG_CLEAR_WAIT   = 3'd5
  } reg_index_t;

  localparam logic [TickW-1:0] PulseReset       = 16'd40;
  localparam logic [TickW-1:0] GapReset         = 16'd40;
  localparam logic [TickW-1:0] DataWaitReset    = 16'd2000;
  localparam logic [TickW-1:0] CommandWaitReset = 16'd5000;
  localparam logic [TickW-1:0] PowerupReset     = 16'd20000;
  localparam logic [TickW-1:0] ClearWaitReset   = 16'd20000;

  typedef struct packed {
    logic [TickW-1:0] pulse_ticks;
    logic [TickW-1:0] gap_ticks;
    logic [TickW-1:0] data_wait_ticks;
    logic [TickW-1:0] command_wait_ticks;
    logic [TickW-1:0] powerup_ticks;
    logic [TickW-1:0] clear_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic       lcd_enable;
    logic       lcd_select;
    logic [3:0] lcd_nibble;
    logic       busy_res;
    logic       accepted;
  } result_t;

  // Power-up command string for 4-bit mode
  function automatic logic [7:0] init_byte(input logic [2:0] step);
    logic [7:0] b;
    case (step)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h33;
      3'd2:    b = 8'h32;
      3'd3:    b = 8'h28;
      3'd4:    b = 8'h0c;
      3'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/lcdw_regs.sv
// Timing configuration registers of the LCD write sequencer.
// Depends on lcdw_pkg.
module lcdw_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  output lcdw_pkg::cfg_t           cfg
);
  import lcdw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks        <= PulseReset;
      cfg.gap_ticks          <= GapReset;
      cfg.data_wait_ticks    <= DataWaitReset;
      cfg.command_wait_ticks <= CommandWaitReset;
      cfg.powerup_ticks      <= PowerupReset;
      cfg.clear_wait_ticks   <= ClearWaitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE:        cfg.pulse_ticks        <= cfg_data;
        REG_GAP:          cfg.gap_ticks          <= cfg_data;
        REG_DATA_WAIT:    cfg.data_wait_ticks    <= cfg_data;
        REG_COMMAND_WAIT: cfg.command_wait_ticks <= cfg_data;
        REG_POWERUP:      cfg.powerup_ticks      <= cfg_data;
        REG_CLEAR_WAIT:   cfg.clear_wait_ticks   <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

### rtl/lcdw_step.sv
// Sequencer state and the per-beat next-state logic of the LCD writer.
// Depends on lcdw_pkg.
module lcdw_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                req_type,
  input  logic                is_data,
  input  logic [7:0]          byte_value,
  input  lcdw_pkg::cfg_t      cfg,
  output lcdw_pkg::result_t   res_next
);
  import lcdw_pkg::*;

  typedef enum logic [3:0] {
    PH_POWERUP    = 4'd0,
    PH_HI_PULSE   = 4'd1,
    PH_GAP        = 4'd2,
    PH_LO_PULSE   = 4'd3,
    PH_WAIT       = 4'd4,
    PH_CLEAR_WAIT = 4'd5,
    PH_IDLE       = 4'd6
  } phase_t;

  phase_t           phase, phase_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_select, held_select_next;
  logic [2:0]       init_step, init_step_next;
  logic             enable_level, enable_level_next;
  logic [3:0]       nibble_out, nibble_out_next;

  logic [TickW-1:0] limit, limit_eff;
  logic [TickW:0]   count_inc;
  logic             done;
  logic             accept_write;

  // Wait length of the current phase; zero counts as one tick
  always_comb begin
    case (phase)
      PH_POWERUP:              limit = cfg.powerup_ticks;
      PH_HI_PULSE, PH_LO_PULSE: limit = cfg.pulse_ticks;
      PH_GAP:                  limit = cfg.gap_ticks;
      PH_WAIT:                 limit = held_select ? cfg.data_wait_ticks
                                                   : cfg.command_wait_ticks;
      PH_CLEAR_WAIT:           limit = cfg.clear_wait_ticks;
      default:                 limit = {{(TickW-1){1'b0}}, 1'b1};
    endcase
    limit_eff = (limit == '0) ? {{(TickW-1){1'b0}}, 1'b1} : limit;
    count_inc = {1'b0, tick_count} + {{TickW{1'b0}}, 1'b1};
    done      = count_inc >= {1'b0, limit_eff};
  end

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    held_byte_next    = held_byte;
    held_select_next  = held_select;
    init_step_next    = init_step;
    enable_level_next = enable_level;
    nibble_out_next   = nibble_out;
    accept_write      = 1'b0;

    if (!req_type) begin
      // Tick: advance the running count, then act on its end
      if (phase != PH_IDLE) begin
        tick_count_next = done ? '0 : count_inc[TickW-1:0];
      end
      case (phase)
        PH_POWERUP: begin
          if (done) begin
            init_step_next    = 3'd0;
            held_byte_next    = init_byte(3'd0);
            held_select_next  = 1'b0;
            nibble_out_next   = held_byte_next[7:4];
            enable_level_next = 1'b1;
            phase_next        = PH_HI_PULSE;
          end
        end
        PH_HI_PULSE: begin
          if (done) begin
            enable_level_next = 1'b0;
            phase_next        = PH_GAP;
          end
        end
        PH_GAP: begin
          if (done) begin
            nibble_out_next   = held_byte[3:0];
            enable_level_next = 1'b1;
            phase_next        = PH_LO_PULSE;
          end
        end
        PH_LO_PULSE: begin
          if (done) begin
            enable_level_next = 1'b0;
            phase_next        = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (done) begin
            if (init_step < 3'(InitCount)) begin
              init_step_next = init_step + 3'd1;
              if (init_step + 3'd1 < 3'(InitCount)) begin
                held_byte_next    = init_byte(init_step + 3'd1);
                held_select_next  = 1'b0;
                nibble_out_next   = held_byte_next[7:4];
                enable_level_next = 1'b1;
                phase_next        = PH_HI_PULSE;
              end else begin
                phase_next = PH_CLEAR_WAIT;
              end
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_CLEAR_WAIT: begin
          if (done) phase_next = PH_IDLE;
        end
        PH_IDLE: ;
        default: phase_next = PH_IDLE;
      endcase
    end else if (phase == PH_IDLE) begin
      // Take the write: latch byte and RS, drive the high nibble, raise E
      accept_write      = 1'b1;
      held_byte_next    = byte_value;
      held_select_next  = is_data;
      nibble_out_next   = byte_value[7:4];
      enable_level_next = 1'b1;
      tick_count_next   = '0;
      phase_next        = PH_HI_PULSE;
    end
  end

  always_comb begin
    res_next.lcd_enable = enable_level_next;
    res_next.lcd_select = held_select_next;
    res_next.lcd_nibble = nibble_out_next;
    res_next.busy_res   = phase_next != PH_IDLE;
    res_next.accepted   = accept_write;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_POWERUP;
      tick_count   <= '0;
      held_byte    <= '0;
      held_select  <= 1'b0;
      init_step    <= '0;
      enable_level <= 1'b0;
      nibble_out   <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      held_byte    <= held_byte_next;
      held_select  <= held_select_next;
      init_step    <= init_step_next;
      enable_level <= enable_level_next;
      nibble_out   <= nibble_out_next;
    end
  end

endmodule

### rtl/lcdw_out_buf.sv
// Two-entry result buffer: a head register plus one skid slot.
// Depends on lcdw_pkg.
module lcdw_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcdw_pkg::result_t   push_data,
  output logic                space,
  output logic                head_valid,
  input  logic                pop,
  output lcdw_pkg::result_t   head_data
);
  import lcdw_pkg::*;

  result_t spare_data;
  logic    spare_valid;

  assign space = !spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        head_data   <= spare_data;
        spare_valid <= 1'b0;
      end else if (push) begin
        head_data <= push_data;
      end else begin
        head_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_data  <= push_data;
        head_valid <= 1'b1;
      end else begin
        spare_data  <= push_data;
        spare_valid <= 1'b1;
      end
    end
  end

endmodule

### rtl/char_lcd_4bit_write_sequencer_unit.sv
// Top level of the character LCD 4-bit write sequencer.
// Depends on lcdw_pkg, lcdw_regs, lcdw_step and lcdw_out_buf.
//
// Usage:
//   Request channel (req_valid/req_ready): one beat is either a
//   one-microsecond tick (req_type = 0) or a write request (req_type = 1)
//   carrying byte_value and is_data (RS). Ticks pace every timed phase:
//   E high for pulse_ticks, E low for gap_ticks, E high for the low nibble,
//   then busy for the data or command wait.
//   Result channel (res_valid/res_ready): one beat per request beat, giving
//   the pin levels (lcd_enable, lcd_select, lcd_nibble) after that beat,
//   busy_res, and accepted (high only for a write taken while idle).
//   Configuration: cfg_we writes cfg_data into register cfg_index; write
//   only while no result is outstanding. Indexes six and seven are dropped.
//   The result of a beat is registered into the head register, or into the
//   skid slot while the head is held. Throughput is one beat per cycle while
//   req_ready is high, set by the single next-state pass in lcdw_step.
//   A stalled receiver fills the two-entry result buffer; req_ready drops
//   only when both entries are held, and rises once the head is taken.
//   Reset loads the default timings, empties the buffer and restarts the
//   power-up wait, after which the init string 33 33 32 28 0c 01 runs.
module char_lcd_4bit_write_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic        is_data,
  input  logic [7:0]  byte_value,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        lcd_enable,
  output logic        lcd_select,
  output logic [3:0]  lcd_nibble,
  output logic        busy_res,
  output logic        accepted,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lcdw_pkg::*;

  cfg_t    cfg;
  result_t res_next;
  result_t res_head;
  logic    req_beat;
  logic    res_beat;

  // A request beat advances the sequencer and pushes its result
  assign req_beat = req_valid && req_ready;
  assign res_beat = res_valid && res_ready;

  lcdw_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdw_step u_step (
    .clk        (clk),
    .rst        (rst),
    .advance    (req_beat),
    .req_type   (req_type),
    .is_data    (is_data),
    .byte_value (byte_value),
    .cfg        (cfg),
    .res_next   (res_next)
  );

  // Hold results here while the receiver stalls
  lcdw_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (req_beat),
    .push_data  (res_next),
    .space      (req_ready),
    .head_valid (res_valid),
    .pop        (res_beat),
    .head_data  (res_head)
  );

  assign lcd_enable = res_head.lcd_enable;
  assign lcd_select = res_head.lcd_select;
  assign lcd_nibble = res_head.lcd_nibble;
  assign busy_res   = res_head.busy_res;
  assign accepted   = res_head.accepted;

  // A taken write raises E with the high nibble and reports busy
  a_write_start: assert property (@(posedge clk) disable iff (rst)
    (req_beat && req_type && res_next.accepted) |->
      (res_next.lcd_enable && res_next.busy_res &&
       res_next.lcd_nibble == byte_value[7:4]))
    else $error("taken write did not start the high nibble pulse");

  // Ticks are never reported as accepted writes
  a_tick_not_taken: assert property (@(posedge clk) disable iff (rst)
    (req_beat && !req_type) |-> !res_next.accepted)
    else $error("tick beat flagged as accepted");

  // The skid slot only fills behind an occupied head
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid)
    else $error("request stalled with an empty result head");

endmodule
